// ===== hw/rtl/jtm_pkg.sv =====
// Shared types, codes and constants of the journal transaction manager.
package jtm_pkg;

  // Field widths fixed by the item format
  localparam int BLK_W       = 24;
  localparam int DEV_W       = 8;
  localparam int CODE_W      = 4;
  localparam int OP_W        = 2;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 64;
  // Width of entry count + (open ops + 1) * blocks per op
  localparam int NEED_W      = 12;

  // Default parameter values
  localparam int DEF_LOG_ENTRIES   = 30;
  localparam int DEF_MAX_OP_BLOCKS = 10;

  // Register reset values
  localparam logic [BLK_W-1:0] LOG_START_RST = 24'd0;
  localparam logic [BLK_W-1:0] LOG_CAP_RST   = 24'd31;
  localparam logic [DEV_W-1:0] DEVICE_RST    = 8'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE    = 2'd2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  // Result codes
  localparam logic [CODE_W-1:0] CODE_GRANTED   = 4'd0;
  localparam logic [CODE_W-1:0] CODE_WAIT      = 4'd1;
  localparam logic [CODE_W-1:0] CODE_ABSORBED  = 4'd2;
  localparam logic [CODE_W-1:0] CODE_APPENDED  = 4'd3;
  localparam logic [CODE_W-1:0] CODE_TOO_BIG   = 4'd4;
  localparam logic [CODE_W-1:0] CODE_OUTSIDE   = 4'd5;
  localparam logic [CODE_W-1:0] CODE_RELEASED  = 4'd6;
  localparam logic [CODE_W-1:0] CODE_NO_OP     = 4'd7;
  localparam logic [CODE_W-1:0] CODE_COPY      = 4'd8;
  localparam logic [CODE_W-1:0] CODE_HEADER    = 4'd9;
  localparam logic [CODE_W-1:0] CODE_INSTALL   = 4'd10;
  localparam logic [CODE_W-1:0] CODE_COMMITTED = 4'd11;

  // One result item
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [BLK_W-1:0]  source_block;
    logic [BLK_W-1:0]  dest_block;
    logic [DEV_W-1:0]  device;
    logic [CNT_W-1:0]  entry_count;
    logic              last;
  } res_t;

endpackage

// ===== hw/rtl/jtm_log_table.sv =====
// Table of logged home block numbers: one write port, one registered read port.
module jtm_log_table import jtm_pkg::*; #(
  parameter int DEPTH = DEF_LOG_ENTRIES,
  parameter int IDX_W = $clog2(DEF_LOG_ENTRIES)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [BLK_W-1:0] wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [BLK_W-1:0] rd_data
);

  logic [BLK_W-1:0] mem [DEPTH];
  logic [BLK_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/jtm_out_reg.sv =====
// Output register of the result channel; holds a result until it is taken.
module jtm_out_reg import jtm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ld,
  input  res_t                  ld_res,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [CODE_W-1:0]     out_tuser,
  output logic                  out_tlast
);

  logic vld_r;
  logic vld_nxt;
  res_t res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (ld) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r <= ld_res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {3'b000, res_r.entry_count, res_r.device,
                       res_r.dest_block, res_r.source_block};
  assign out_tuser  = res_r.code;
  assign out_tlast  = res_r.last;

endmodule

// ===== hw/rtl/journal_transaction_manager_core.sv =====
// Top level of the journal transaction manager with group commit.
//
// The core keeps the state of one running write-ahead journal transaction:
// a table of logged home block numbers, the entry count and the count of
// open operations. Each input transaction carries an operation in in_tuser
// (begin, write, end) and a home block number in in_tdata. Begin answers
// granted or wait, write answers absorbed, appended, too big or outside,
// and end answers released or no op; the end that closes the last open
// operation instead emits the whole group commit: one copy-to-log command
// per entry, a header write with the count, one install command per entry,
// a header write with count zero and a final committed result. out_tlast
// marks the last result of each input transaction, and an unused operation
// code is taken and dropped without a result. The core works on one input
// transaction at a time and is ready only when idle. A write that must
// search the table reads one table entry per cycle through the table's
// single read port and one shared comparator; a commit emits one result
// per cycle through the shared slot-address adder while out_tready does
// not stall, and with an empty table it emits only the committed result.
// Configuration writes are taken in any cycle but are only meant for times
// when the core is idle and the result channel has drained.
module journal_transaction_manager_core import jtm_pkg::*; #(
  parameter int LOG_ENTRIES   = DEF_LOG_ENTRIES,
  parameter int MAX_OP_BLOCKS = DEF_MAX_OP_BLOCKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BLK_W-1:0]      cfg_wdata,
  // Input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [23:0] block_number
  input  logic [OP_W-1:0]       in_tuser,   // [1:0] operation
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [23:0] source_block, [47:24] dest_block,
                                            // [55:48] device, [60:56] entry_count, rest 0
  output logic [CODE_W-1:0]     out_tuser,  // [3:0] code
  output logic                  out_tlast
);

  localparam int IDX_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ONE  = 3'd1;  // single result pending
  localparam logic [2:0] ST_SRCH = 3'd2;  // walk the table for a match
  localparam logic [2:0] ST_COPY = 3'd3;  // copy entries to log slots
  localparam logic [2:0] ST_HDR1 = 3'd4;  // header with the entry count
  localparam logic [2:0] ST_INST = 3'd5;  // install log slots at home
  localparam logic [2:0] ST_HDR0 = 3'd6;  // header cleared
  localparam logic [2:0] ST_FIN  = 3'd7;  // committed

  // Configuration registers
  logic [BLK_W-1:0] log_start_r;
  logic [BLK_W-1:0] log_cap_r;
  logic [DEV_W-1:0] dev_r;

  // Sequencer and transaction state
  logic [2:0]        state_r,  state_nxt;
  logic [CNT_W-1:0]  idx_r,    idx_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [CNT_W-1:0]  open_r,   open_nxt;
  logic [CODE_W-1:0] code_r,   code_nxt;
  logic [BLK_W-1:0]  blk_r,    blk_nxt;

  // Table ports
  logic             tbl_we;
  logic [BLK_W-1:0] tbl_rd_data;

  // Output register load
  logic ld;
  res_t ld_res;

  logic              in_fire;
  logic              can_emit;
  logic [NEED_W-1:0] need;
  logic              too_big;
  logic [BLK_W-1:0]  slot_addr;
  logic              idx_at_end;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  // The output register is free now or is being emptied this cycle
  assign can_emit  = !out_tvalid || out_tready;

  // Space the open operations could claim with one more operation
  assign need = NEED_W'(cnt_r)
              + (NEED_W'(open_r) + NEED_W'(1)) * NEED_W'(MAX_OP_BLOCKS);

  assign too_big = (cnt_r >= CNT_W'(LOG_ENTRIES))
                || ((BLK_W'(cnt_r) + BLK_W'(1)) >= log_cap_r);

  // Shared slot-address adder: log slot of entry idx_r
  assign slot_addr  = log_start_r + BLK_W'(idx_r) + BLK_W'(1);
  assign idx_at_end = (idx_r == (cnt_r - CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_start_r <= LOG_START_RST;
      log_cap_r   <= LOG_CAP_RST;
      dev_r       <= DEVICE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOG_START: log_start_r <= cfg_wdata;
        CFG_LOG_CAP:   log_cap_r   <= cfg_wdata;
        CFG_DEVICE:    dev_r       <= cfg_wdata[DEV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    open_nxt  = open_r;
    code_nxt  = code_r;
    blk_nxt   = blk_r;
    tbl_we    = 1'b0;
    ld        = 1'b0;
    ld_res    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          blk_nxt = in_tdata[BLK_W-1:0];
          idx_nxt = '0;
          unique case (in_tuser)
            OP_BEGIN: begin
              priority if (need > NEED_W'(LOG_ENTRIES)) begin
                code_nxt = CODE_WAIT;
              end else begin
                open_nxt = open_r + CNT_W'(1);
                code_nxt = CODE_GRANTED;
              end
              state_nxt = ST_ONE;
            end
            OP_WRITE: begin
              state_nxt = ST_ONE;
              priority if (too_big) begin
                code_nxt = CODE_TOO_BIG;
              end else if (open_r == '0) begin
                code_nxt = CODE_OUTSIDE;
              end else if (cnt_r == '0) begin
                // Empty table: append at once
                tbl_we   = 1'b1;
                cnt_nxt  = CNT_W'(1);
                code_nxt = CODE_APPENDED;
              end else begin
                state_nxt = ST_SRCH;
              end
            end
            OP_END: begin
              priority if (open_r == '0) begin
                code_nxt  = CODE_NO_OP;
                state_nxt = ST_ONE;
              end else if (open_r != CNT_W'(1)) begin
                open_nxt  = open_r - CNT_W'(1);
                code_nxt  = CODE_RELEASED;
                state_nxt = ST_ONE;
              end else begin
                open_nxt  = '0;
                state_nxt = (cnt_r == '0) ? ST_FIN : ST_COPY;
              end
            end
            default: ;  // unused operation: drop
          endcase
        end
      end

      ST_ONE: begin
        if (can_emit) begin
          ld          = 1'b1;
          ld_res.code = code_r;
          ld_res.last = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      ST_SRCH: begin
        priority if (tbl_rd_data == blk_r) begin
          code_nxt  = CODE_ABSORBED;
          state_nxt = ST_ONE;
        end else if (idx_at_end) begin
          tbl_we    = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          code_nxt  = CODE_APPENDED;
          state_nxt = ST_ONE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      ST_COPY: begin
        if (can_emit) begin
          ld                  = 1'b1;
          ld_res.code         = CODE_COPY;
          ld_res.source_block = tbl_rd_data;
          ld_res.dest_block   = slot_addr;
          ld_res.device       = dev_r;
          if (idx_at_end) begin
            state_nxt = ST_HDR1;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end

      ST_HDR1: begin
        if (can_emit) begin
          ld                 = 1'b1;
          ld_res.code        = CODE_HEADER;
          ld_res.dest_block  = log_start_r;
          ld_res.device      = dev_r;
          ld_res.entry_count = cnt_r;
          idx_nxt            = '0;
          state_nxt          = ST_INST;
        end
      end

      ST_INST: begin
        if (can_emit) begin
          ld                  = 1'b1;
          ld_res.code         = CODE_INSTALL;
          ld_res.source_block = slot_addr;
          ld_res.dest_block   = tbl_rd_data;
          ld_res.device       = dev_r;
          if (idx_at_end) begin
            state_nxt = ST_HDR0;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end

      ST_HDR0: begin
        if (can_emit) begin
          ld                = 1'b1;
          ld_res.code       = CODE_HEADER;
          ld_res.dest_block = log_start_r;
          ld_res.device     = dev_r;
          state_nxt         = ST_FIN;
        end
      end

      ST_FIN: begin
        if (can_emit) begin
          ld          = 1'b1;
          ld_res.code = CODE_COMMITTED;
          ld_res.last = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
      open_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      open_r  <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    blk_r  <= blk_nxt;
  end

  // Read address follows the next index, so the registered read data
  // always matches idx_r; append writes at the current count.
  jtm_log_table #(
    .DEPTH (LOG_ENTRIES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (blk_nxt),
    .rd_addr (idx_nxt[IDX_W-1:0]),
    .rd_data (tbl_rd_data)
  );

  jtm_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .ld_res     (ld_res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The table never holds more entries than it has rows
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LOG_ENTRIES))
    else $error("entry count beyond table depth");

  // A search only visits logged entries
  a_srch_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (idx_r < cnt_r))
    else $error("search index past entry count");

  // The last result of a transaction returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && ld_res.last) |=> (state_r == ST_IDLE))
    else $error("sequencer busy after last result");

  // A commit leaves no open operation behind
  a_commit_open: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && (ld_res.code == CODE_COMMITTED)) |-> (open_r == '0))
    else $error("commit with open operations");

endmodule

// ===== sim/journal_transaction_manager_core_test.sv =====
// Self-checking testbench for the journal transaction manager core.
module journal_transaction_manager_core_test;
  import jtm_pkg::*;

  // The package names no unused operation; the core must drop it silently
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Slowest correct run: ~270 transactions, each up to 63 results under
  // random stalls, plus search, gaps and one hold-off; the limit is several
  // times that.
  localparam int CYCLE_LIMIT  = 500000;
  // Longest busy time of an item that yields nothing: a full table search
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 37;

  // Tracks the journal state and the results the core owes, in order.
  class journal_tracker;
    res_t             awaited_results[$];
    logic [BLK_W-1:0] logged_blocks[DEF_LOG_ENTRIES];
    int unsigned      entries;
    int unsigned      open_ops;
    logic [BLK_W-1:0] log_start;
    logic [BLK_W-1:0] log_capacity;
    logic [DEV_W-1:0] device_id;
    int               errors;

    function new();
      log_start    = LOG_START_RST;
      log_capacity = LOG_CAP_RST;
      device_id    = DEVICE_RST;
      entries      = 0;
      open_ops     = 0;
      errors       = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [BLK_W-1:0] value);
      case (index)
        CFG_LOG_START: log_start = value;
        CFG_LOG_CAP:   log_capacity = value;
        CFG_DEVICE:    device_id = value[DEV_W-1:0];
        default: ;
      endcase
    endfunction

    function void owe(logic [CODE_W-1:0] code, logic [BLK_W-1:0] src,
                      logic [BLK_W-1:0] dst, logic [DEV_W-1:0] dev, logic [CNT_W-1:0] cnt);
      res_t r;
      r.code         = code;
      r.source_block = src;
      r.dest_block   = dst;
      r.device       = dev;
      r.entry_count  = cnt;
      r.last         = 1'b0;
      awaited_results.push_back(r);
    endfunction

    // Apply one accepted request and queue the results it causes.
    function void take_request(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
      int               queued;
      bit               found;
      logic [BLK_W-1:0] slot;
      res_t             tail;
      queued = awaited_results.size();
      found  = 1'b0;
      case (op)
        OP_BEGIN: begin
          if (entries + (open_ops + 1) * DEF_MAX_OP_BLOCKS > DEF_LOG_ENTRIES) begin
            owe(CODE_WAIT, 0, 0, 0, 0);
          end else begin
            open_ops = (open_ops + 1) % 32;
            owe(CODE_GRANTED, 0, 0, 0, 0);
          end
        end
        OP_WRITE: begin
          // Too big takes precedence over a write outside a transaction
          if (entries >= DEF_LOG_ENTRIES || entries + 1 >= log_capacity) begin
            owe(CODE_TOO_BIG, 0, 0, 0, 0);
          end else if (open_ops == 0) begin
            owe(CODE_OUTSIDE, 0, 0, 0, 0);
          end else begin
            for (int i = 0; i < entries; i++)
              if (logged_blocks[i] == blk) found = 1'b1;
            if (found) begin
              owe(CODE_ABSORBED, 0, 0, 0, 0);
            end else begin
              logged_blocks[entries] = blk;
              entries++;
              owe(CODE_APPENDED, 0, 0, 0, 0);
            end
          end
        end
        OP_END: begin
          if (open_ops == 0) begin
            owe(CODE_NO_OP, 0, 0, 0, 0);
          end else begin
            open_ops--;
            if (open_ops != 0) begin
              owe(CODE_RELEASED, 0, 0, 0, 0);
            end else begin
              // Group commit: copy out, header, install, clear header
              if (entries > 0) begin
                for (int i = 0; i < entries; i++) begin
                  slot = log_start + BLK_W'(i) + BLK_W'(1);
                  owe(CODE_COPY, logged_blocks[i], slot, device_id, 0);
                end
                owe(CODE_HEADER, 0, log_start, device_id, CNT_W'(entries));
                for (int i = 0; i < entries; i++) begin
                  slot = log_start + BLK_W'(i) + BLK_W'(1);
                  owe(CODE_INSTALL, slot, logged_blocks[i], device_id, 0);
                end
                owe(CODE_HEADER, 0, log_start, device_id, 0);
              end
              entries = 0;
              owe(CODE_COMMITTED, 0, 0, 0, 0);
            end
          end
        end
        default: ;
      endcase
      // Flag the final result of this request
      if (awaited_results.size() > queued) begin
        tail = awaited_results.pop_back();
        tail.last = 1'b1;
        awaited_results.push_back(tail);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected, actual code %0d", $time, got.code);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("code", 32'(want.code), 32'(got.code));
      compare_field("source_block", 32'(want.source_block), 32'(got.source_block));
      compare_field("dest_block", 32'(want.dest_block), 32'(got.dest_block));
      compare_field("device", 32'(want.device), 32'(got.device));
      compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [BLK_W-1:0]      cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [23:0] block_number
  logic [OP_W-1:0]       in_tuser;   // [1:0] operation
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [23:0] source, [47:24] dest, [55:48] device,
                                     // [60:56] entry_count
  logic [CODE_W-1:0]     out_tuser;  // [3:0] code
  logic                  out_tlast;

  journal_tracker journal = new();

  bit               tx_idle_on;
  bit               rx_idle_on;
  int               hold_requests = 0;
  int               holds_served = 0;
  int               items_sent = 0;
  int               cycle_count = 0;
  logic [BLK_W-1:0] block_pool[6];

  always #5 clk = ~clk;

  journal_transaction_manager_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      journal.take_request(in_tuser, in_tdata[BLK_W-1:0]);
  end

  // Check every accepted result transaction against the oldest expectation
  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.code         = out_tuser;
      got.source_block = out_tdata[23:0];
      got.dest_block   = out_tdata[47:24];
      got.device       = out_tdata[55:48];
      got.entry_count  = out_tdata[60:56];
      got.last         = out_tlast;
      journal.check_result(got);
    end
  end

  // Receiver: random stalls, or one long hold-off when the stimulus asks
  // for it. The hold is counted here so the sender keeps offering meanwhile.
  initial begin : receiver
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (holds_served != hold_requests) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one request and hold it until the core takes the transaction.
  task automatic send_item(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= blk;
    do @(posedge clk); while (!in_tready);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Drop valid, wait until every owed result is in, then let the core go idle.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (journal.awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [BLK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    journal.write_register(index, value);
  endtask

  task automatic configure(logic [BLK_W-1:0] start, logic [BLK_W-1:0] capacity,
                           logic [DEV_W-1:0] dev);
    settle();
    write_register(CFG_LOG_START, start);
    write_register(CFG_LOG_CAP, capacity);
    write_register(CFG_DEVICE, BLK_W'(dev));
    cfg_we <= 1'b0;
  endtask

  // One journal operation: begins, writes, matching ends. A fill writes
  // fresh blocks past the table size to reach the full commit and too big.
  task automatic run_transaction(bit fill);
    int depth;
    int writes;
    bit fresh;
    depth  = ($urandom_range(9) == 0) ? $urandom_range(3, 2) : 1;
    fresh  = fill || ($urandom_range(19) == 0);
    writes = fresh ? 32 : $urandom_range(8);
    send_item(OP_BEGIN, BLK_W'($urandom));
    // Nested: log one block before the other begins so the wait check sees it
    if (depth > 1) begin
      send_item(OP_WRITE, block_pool[$urandom_range(5)]);
      repeat (depth - 1) send_item(OP_BEGIN, BLK_W'($urandom));
    end
    for (int w = 0; w < writes; w++)
      send_item(OP_WRITE, (!fresh && $urandom_range(9) < 6) ?
                          block_pool[$urandom_range(5)] : BLK_W'($urandom));
    repeat (depth) send_item(OP_END, BLK_W'($urandom));
  endtask

  // Mostly well-formed operations, the rest random requests as noise.
  task automatic run_random(int count);
    int target;
    target = items_sent + count;
    foreach (block_pool[p]) block_pool[p] = BLK_W'($urandom);
    while (items_sent < target) begin
      if ($urandom_range(99) < 75) run_transaction(1'b0);
      else send_item(OP_W'($urandom_range(3)), BLK_W'($urandom));
    end
  endtask

  initial begin : stimulus
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_LOG_START;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_BEGIN;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: slot addresses wrap past the top of the block space
    configure(24'hFFFFFE, 24'd31, 8'hFF);
    send_item(OP_END, 24'h000000);        // end with nothing open
    send_item(OP_WRITE, 24'h000000);      // write outside a transaction
    send_item(OP_UNUSED, 24'hFFFFFF);     // dropped without a result
    repeat (3) send_item(OP_BEGIN, 24'h000000);
    send_item(OP_BEGIN, 24'h000000);      // reservation overflows: wait
    send_item(OP_WRITE, 24'hFFFFFF);
    send_item(OP_WRITE, 24'h000000);
    send_item(OP_WRITE, 24'hFFFFFF);      // already logged: absorbed
    send_item(OP_WRITE, 24'hAAAAAA);
    send_item(OP_WRITE, 24'h555555);
    send_item(OP_END, 24'h000000);
    send_item(OP_END, 24'h000000);
    send_item(OP_BEGIN, 24'h000000);
    send_item(OP_END, 24'h000000);
    send_item(OP_END, 24'h000000);        // last close: group commit

    // Directed: capacity below two means every write is too big
    configure(24'h000000, 24'd1, 8'h5A);
    send_item(OP_WRITE, 24'h123456);
    configure(24'h123456, 24'd2, 8'hA5);
    send_item(OP_BEGIN, 24'h000000);
    send_item(OP_WRITE, 24'h800001);
    send_item(OP_WRITE, 24'h7FFFFE);      // log full for this capacity
    send_item(OP_END, 24'h000000);

    configure(BLK_W'($urandom), 24'd31, DEV_W'($urandom));
    run_random(55);

    // Stall the result side long enough to back up the input side
    hold_requests++;
    run_transaction(1'b1);

    // Long stretch with no idling on either side, widest capacity
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    configure(24'h000000, 24'hFFFFFF, 8'h00);
    run_random(50);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    configure(24'hFFFFFF, 24'd12, 8'h80);
    run_random(50);

    configure(BLK_W'($urandom), BLK_W'($urandom_range(40, 2)), DEV_W'($urandom));
    run_random(45);

    settle();
    if (journal.errors == 0 && journal.awaited_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/jtm_pkg.sv
hw/rtl/jtm_log_table.sv
hw/rtl/jtm_out_reg.sv
hw/rtl/journal_transaction_manager_core.sv
sim/journal_transaction_manager_core_test.sv
